// ----- src/ftt_pkg.sv -----
package ftt_pkg;

  localparam int MAX_LEN_DEFAULT = 4096;
  localparam int EV_DEPTH = 4;
  localparam int OUT_DEPTH = 8;
  localparam int OUT_BURST = 3;
  localparam logic [11:0] MAX_PARTS_RESET = 12'd1024;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

  typedef enum logic [3:0] {
    KIND_LIT, KIND_BOL, KIND_EOL, KIND_TIME, KIND_HOST, KIND_MSG, KIND_UID,
    KIND_GID, KIND_PID, KIND_PRI, KIND_HASH, KIND_TAG, KIND_CONTENT, KIND_ERR
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE, ERR_MANY, ERR_CODE, ERR_TRAIL
  } err_t;

  typedef enum logic {
    OP_CHAR, OP_END
  } op_t;

  typedef struct packed {
    logic  is_end;
    logic  has_char;
    logic  is_pct;
    kind_t code;
  } ev_class_t;

  typedef struct packed {
    kind_t       kind;
    err_t        error_code;
    logic [12:0] seg_start;
    logic [12:0] seg_len;
    logic        last;
  } res_t;

endpackage

// ----- src/format_template_tokenizer.sv -----
// Channel  | Signals                                         | Handshake
// input    | op, ch                                          | push, full
// result   | kind, error_code, seg_start, seg_len, last      | pop, empty
// config   | max_parts_data                                  | max_parts_wr
//
// One template character is accepted every cycle while full is low.
// An accepted item is written into the event queue; the parser's results for it are
// then written into the result queue, from which they appear on the result ports.
// The parser takes one item a cycle from a four-entry queue while the eight-entry
// result queue has room for three results; otherwise it holds and the queue fills.
// Reset is synchronous and empties both queues and clears the template state.
module format_template_tokenizer
  import ftt_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        op,
  input  logic [7:0]  ch,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  kind,
  output logic [1:0]  error_code,
  output logic [12:0] seg_start,
  output logic [12:0] seg_len,
  output logic        last,
  input  logic        max_parts_wr,
  input  logic [11:0] max_parts_data
);

  localparam int PW = $clog2(MAX_LEN + 1);
  localparam int EVW = $bits(ev_class_t) + PW;

  ev_class_t            f_class;
  logic [PW-1:0]        f_pos;
  logic                 accept;
  logic [EVW-1:0]       q_rdata;
  logic                 q_empty;
  ev_class_t            b_class;
  logic [PW-1:0]        b_pos;
  logic                 b_pop;
  logic                 out_room;
  logic [1:0]           res_count;
  res_t [OUT_BURST-1:0] res;
  res_t                 head;

  assign accept = push && !full;

  ftt_front #(
    .MAX_LEN(MAX_LEN),
    .PW     (PW)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .op      (op),
    .ch      (ch),
    .ev_class(f_class),
    .ev_pos  (f_pos)
  );

  ftt_fifo #(
    .WIDTH(EVW),
    .DEPTH(EV_DEPTH)
  ) u_evq (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata({f_class, f_pos}),
    .full (full),
    .pop  (b_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  assign {b_class, b_pos} = q_rdata;

  ftt_back #(
    .PW(PW)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .max_parts_wr  (max_parts_wr),
    .max_parts_data(max_parts_data),
    .ev_valid      (!q_empty),
    .ev_class      (b_class),
    .ev_pos        (b_pos),
    .ev_pop        (b_pop),
    .out_room      (out_room),
    .res_count     (res_count),
    .res           (res)
  );

  ftt_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push_count(res_count),
    .push_data (res),
    .room      (out_room),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  assign kind       = head.kind;
  assign error_code = head.error_code;
  assign seg_start  = head.seg_start;
  assign seg_len    = head.seg_len;
  assign last       = head.last;

endmodule

// ----- src/ftt_fifo.sv -----
module ftt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

// ----- src/ftt_front.sv -----
module ftt_front
  import ftt_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEFAULT,
  parameter int PW = $clog2(MAX_LEN + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic            op,
  input  logic [7:0]      ch,
  output ev_class_t       ev_class,
  output logic [PW-1:0]   ev_pos
);

  logic          escape_pending;
  logic          escape_pending_next;
  logic [PW-1:0] decoded_position;
  logic [PW-1:0] decoded_position_next;
  logic [7:0]    dec_ch;
  logic          char_valid;

  function automatic kind_t code_kind(logic [7:0] c);
    case (c)
      8'h74:   return KIND_TIME;
      8'h68:   return KIND_HOST;
      8'h6D:   return KIND_MSG;
      8'h75:   return KIND_UID;
      8'h67:   return KIND_GID;
      8'h70:   return KIND_PID;
      8'h50:   return KIND_PRI;
      8'h48:   return KIND_HASH;
      8'h54:   return KIND_TAG;
      8'h43:   return KIND_CONTENT;
      default: return KIND_LIT;
    endcase
  endfunction

  always_comb begin
    dec_ch = ch;
    if (escape_pending) begin
      case (ch)
        8'h62:   dec_ch = 8'h08;
        8'h66:   dec_ch = 8'h0C;
        8'h6E:   dec_ch = 8'h0A;
        8'h72:   dec_ch = 8'h0D;
        8'h74:   dec_ch = 8'h09;
        default: dec_ch = ch;
      endcase
    end
  end

  always_comb begin
    escape_pending_next   = escape_pending;
    decoded_position_next = decoded_position;
    char_valid            = 1'b0;
    ev_class.is_end       = (op == OP_END);
    ev_class.is_pct       = (dec_ch == CH_PERCENT);
    ev_class.code         = code_kind(dec_ch);
    ev_pos                = decoded_position;
    if (op == OP_END) begin
      escape_pending_next   = 1'b0;
      decoded_position_next = '0;
    end else if (escape_pending) begin
      escape_pending_next = 1'b0;
      char_valid          = 1'b1;
    end else if (ch == CH_BACKSLASH) begin
      escape_pending_next = 1'b1;
    end else begin
      char_valid = 1'b1;
    end
    ev_class.has_char = char_valid && (decoded_position < PW'(MAX_LEN));
    if (ev_class.has_char) begin
      decoded_position_next = decoded_position + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending   <= 1'b0;
      decoded_position <= '0;
    end else if (accept) begin
      escape_pending   <= escape_pending_next;
      decoded_position <= decoded_position_next;
    end
  end

endmodule

// ----- src/ftt_back.sv -----
module ftt_back
  import ftt_pkg::*;
#(
  parameter int PW = 13
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  max_parts_wr,
  input  logic [11:0]           max_parts_data,
  input  logic                  ev_valid,
  input  ev_class_t             ev_class,
  input  logic [PW-1:0]         ev_pos,
  output logic                  ev_pop,
  input  logic                  out_room,
  output logic [1:0]            res_count,
  output res_t [OUT_BURST-1:0]  res
);

  localparam int EW = (PW > 13) ? PW : 13;

  typedef struct packed {
    logic [1:0]           cnt;
    logic                 failed;
    logic [11:0]          pc;
    res_t [OUT_BURST-1:0] res;
  } emit_t;

  logic [11:0]   max_parts;
  logic          percent_pending;
  logic          percent_pending_next;
  logic [PW-1:0] literal_start;
  logic [PW-1:0] literal_start_next;
  logic [11:0]   part_count;
  logic [11:0]   part_count_next;
  logic          begun;
  logic          begun_next;
  logic          failed;
  logic          failed_next;
  emit_t         e;

  function automatic logic [12:0] to13(logic [PW-1:0] v);
    logic [EW-1:0] w;
    w = EW'(v);
    return w[12:0];
  endfunction

  function automatic emit_t add_part(emit_t ei, kind_t k, logic [12:0] s, logic [12:0] l,
                                     logic lst, logic [11:0] mx);
    emit_t eo;
    res_t  r;
    eo           = ei;
    r.kind       = k;
    r.error_code = ERR_NONE;
    r.seg_start  = s;
    r.seg_len    = l;
    r.last       = lst;
    if (ei.pc >= mx) begin
      r.kind       = KIND_ERR;
      r.error_code = ERR_MANY;
      r.seg_start  = '0;
      r.seg_len    = '0;
      r.last       = 1'b1;
      eo.failed    = 1'b1;
    end else begin
      eo.pc = ei.pc + 1'b1;
    end
    eo.res[ei.cnt] = r;
    eo.cnt         = ei.cnt + 1'b1;
    return eo;
  endfunction

  function automatic emit_t fail_part(emit_t ei, err_t err);
    emit_t eo;
    res_t  r;
    eo             = ei;
    r.kind         = KIND_ERR;
    r.error_code   = err;
    r.seg_start    = '0;
    r.seg_len      = '0;
    r.last         = 1'b1;
    eo.failed      = 1'b1;
    eo.res[ei.cnt] = r;
    eo.cnt         = ei.cnt + 1'b1;
    return eo;
  endfunction

  assign ev_pop = ev_valid && out_room;

  always_comb begin
    e                    = '0;
    e.pc                 = part_count;
    e.failed             = failed;
    begun_next           = begun;
    percent_pending_next = percent_pending;
    literal_start_next   = literal_start;
    if (!e.failed && !begun) begin
      begun_next = 1'b1;
      e = add_part(e, KIND_BOL, '0, '0, 1'b0, max_parts);
    end
    if (!ev_class.is_end) begin
      if (!e.failed && ev_class.has_char) begin
        if (percent_pending) begin
          percent_pending_next = 1'b0;
          if (ev_class.is_pct) begin
            e = add_part(e, KIND_LIT, to13(literal_start),
                         to13(ev_pos - 1'b1 - literal_start), 1'b0, max_parts);
            if (!e.failed) begin
              literal_start_next = ev_pos;
            end
          end else if (ev_class.code == KIND_LIT) begin
            e = fail_part(e, ERR_CODE);
          end else begin
            if (ev_pos - 1'b1 > literal_start) begin
              e = add_part(e, KIND_LIT, to13(literal_start),
                           to13(ev_pos - 1'b1 - literal_start), 1'b0, max_parts);
            end
            if (!e.failed) begin
              e = add_part(e, ev_class.code, '0, '0, 1'b0, max_parts);
              if (!e.failed) begin
                literal_start_next = ev_pos + 1'b1;
              end
            end
          end
        end else if (ev_class.is_pct) begin
          percent_pending_next = 1'b1;
        end
      end
    end else begin
      if (!e.failed) begin
        if (percent_pending) begin
          e = fail_part(e, ERR_TRAIL);
        end else if (literal_start != ev_pos) begin
          e = add_part(e, KIND_LIT, to13(literal_start), to13(ev_pos - literal_start),
                       1'b0, max_parts);
          if (!e.failed) begin
            e = add_part(e, KIND_EOL, '0, '0, 1'b1, max_parts);
          end
        end else begin
          e = add_part(e, KIND_EOL, '0, '0, 1'b1, max_parts);
        end
      end
      begun_next           = 1'b0;
      percent_pending_next = 1'b0;
      literal_start_next   = '0;
    end
    part_count_next = ev_class.is_end ? '0 : e.pc;
    failed_next     = ev_class.is_end ? 1'b0 : e.failed;
  end

  assign res_count = ev_pop ? e.cnt : 2'd0;
  assign res       = e.res;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_parts <= MAX_PARTS_RESET;
    end else if (max_parts_wr) begin
      max_parts <= max_parts_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      percent_pending <= 1'b0;
      literal_start   <= '0;
      part_count      <= '0;
      begun           <= 1'b0;
      failed          <= 1'b0;
    end else if (ev_pop) begin
      percent_pending <= percent_pending_next;
      literal_start   <= literal_start_next;
      part_count      <= part_count_next;
      begun           <= begun_next;
      failed          <= failed_next;
    end
  end

endmodule

// ----- src/ftt_outq.sv -----
module ftt_outq
  import ftt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           push_count,
  input  res_t [OUT_BURST-1:0] push_data,
  output logic                 room,
  input  logic                 pop,
  output res_t                 head,
  output logic                 empty
);

  localparam int AW = $clog2(OUT_DEPTH);
  localparam int CW = $clog2(OUT_DEPTH + 1);

  res_t          mem [OUT_DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_pop;

  assign empty  = (count == '0);
  assign room   = (count <= CW'(OUT_DEPTH - OUT_BURST));
  assign do_pop = pop && !empty;
  assign head   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + AW'(push_count);
      rptr  <= rptr + AW'(do_pop);
      count <= count + CW'(push_count) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < OUT_BURST; i++) begin
      if (2'(i) < push_count) begin
        mem[wptr + AW'(i)] <= push_data[i];
      end
    end
  end

endmodule

// ----- src/ftt_checker.sv -----
module ftt_checker
  import ftt_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [3:0]  kind,
  input logic [1:0]  error_code,
  input logic [12:0] seg_start,
  input logic [12:0] seg_len,
  input logic        last
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("Result queue is not empty after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(kind) && $stable(seg_start) && $stable(last)))
    else $error("Waiting result changed before it was taken.");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    (!empty && last) |-> (kind == KIND_EOL || kind == KIND_ERR))
    else $error("Final result is neither an end part nor an error.");

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((kind == KIND_ERR) == (error_code != ERR_NONE)))
    else $error("Error code does not match the result kind.");

  a_seg_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != KIND_LIT) |-> (seg_start == '0 && seg_len == '0))
    else $error("Non-literal result carries a segment.");

endmodule

bind format_template_tokenizer ftt_checker u_checker (.*);
